// File: design/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// shared types and constants of the four-bit accumulator cpu
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int PROG_WORDS = 16;
  localparam int RAM_WORDS  = 16;
  localparam int PROG_AW    = $clog2(PROG_WORDS);
  localparam int RAM_AW     = $clog2(RAM_WORDS);
  localparam int WORD_W     = 8;
  localparam int FIELD_W    = 4;
  localparam int PC_W       = 5;
  localparam int PROG_REG_W = 64;

  localparam logic [PC_W-1:0] PC_IDLE = 5'h1F;   // minus one
  localparam logic [PC_W-1:0] PC_LAST = 5'd15;

  // configuration register indexes
  localparam logic CFG_PROG_LOW  = 1'b0;
  localparam logic CFG_PROG_HIGH = 1'b1;

  // start / tick command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [FIELD_W-1:0] {
    OP_HLT = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_STO = 4'd3,
    OP_LD  = 4'd4,
    OP_B   = 4'd5,
    OP_BZ  = 4'd6,
    OP_LDV = 4'd7,
    OP_INP = 4'd8,
    OP_OUT = 4'd9,
    OP_AND = 4'd10,
    OP_OR  = 4'd11,
    OP_NOT = 4'd12
  } op_t;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] input_value;
  } item_t;

  typedef struct packed {
    logic                   is_running;
    logic signed [PC_W-1:0] program_counter;
    logic [FIELD_W-1:0]     out_value;
    logic                   out_strobe;
    logic [FIELD_W-1:0]     acc_value;
    logic [FIELD_W-1:0]     operand_done;
    logic [FIELD_W-1:0]     opcode_done;
    logic                   executed;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// File: design/acpu_prog.sv
// ----------------------------------------------------------------------------
// acpu_prog
// program store: two 64-bit configuration registers and the word fetch
// ----------------------------------------------------------------------------
module acpu_prog (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [acpu_pkg::PROG_REG_W-1:0]     cfg_data,
  input  logic [acpu_pkg::PROG_AW-1:0]        fetch_addr,
  output logic [acpu_pkg::WORD_W-1:0]         fetch_word
);

  logic [acpu_pkg::PROG_REG_W-1:0] program_low;
  logic [acpu_pkg::PROG_REG_W-1:0] program_high;
  logic [acpu_pkg::PROG_REG_W-1:0] page;
  logic [acpu_pkg::PROG_AW-2:0]    slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_low  <= '0;
      program_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acpu_pkg::CFG_PROG_LOW:  program_low  <= cfg_data;
        acpu_pkg::CFG_PROG_HIGH: program_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // top address bit picks the register, low bits pick the byte
  assign page       = fetch_addr[acpu_pkg::PROG_AW-1] ? program_high : program_low;
  assign slot       = fetch_addr[acpu_pkg::PROG_AW-2:0];
  assign fetch_word = page[{slot, 3'b000} +: acpu_pkg::WORD_W];

endmodule

// File: design/acpu_exec.sv
// ----------------------------------------------------------------------------
// acpu_exec
// machine state and instruction execute (next state computed combinationally)
// ----------------------------------------------------------------------------
module acpu_exec #(
  parameter int DATA_WIDTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  acpu_pkg::item_t               item,
  input  logic [acpu_pkg::WORD_W-1:0]   fetch_word,
  output logic [acpu_pkg::PROG_AW-1:0]  fetch_addr,
  output acpu_pkg::result_t             result
);

  logic [DATA_WIDTH-1:0]         acc, acc_next;
  logic [DATA_WIDTH-1:0]         out_reg, out_reg_next;
  logic [acpu_pkg::PC_W-1:0]     counter, counter_next;
  logic                          running, running_next;
  logic [DATA_WIDTH-1:0]         data_ram [acpu_pkg::RAM_WORDS];

  logic [acpu_pkg::PC_W-1:0]     pc_inc;
  logic [acpu_pkg::FIELD_W-1:0]  opc, opd;
  logic [acpu_pkg::RAM_AW-1:0]   ram_addr;
  logic [DATA_WIDTH-1:0]         ram_rd;
  logic                          ram_we;
  logic                          exec, strobe;

  assign pc_inc     = counter + 1'b1;
  assign fetch_addr = pc_inc[acpu_pkg::PROG_AW-1:0];
  assign opd        = fetch_word[acpu_pkg::FIELD_W-1:0];
  assign ram_addr   = opd[acpu_pkg::RAM_AW-1:0];
  assign ram_rd     = data_ram[ram_addr];

  always_comb begin
    acc_next     = acc;
    out_reg_next = out_reg;
    counter_next = counter;
    running_next = running;
    ram_we       = 1'b0;
    exec         = 1'b0;
    strobe       = 1'b0;
    opc          = '0;
    if (item.command == acpu_pkg::CMD_START) begin
      running_next = 1'b1;
      counter_next = acpu_pkg::PC_IDLE;
    end else if (running) begin
      if (counter == acpu_pkg::PC_LAST) begin
        // stepped past the last word
        counter_next = acpu_pkg::PC_IDLE;
        running_next = 1'b0;
      end else begin
        counter_next = pc_inc;
        exec         = 1'b1;
        opc          = fetch_word[acpu_pkg::WORD_W-1 -: acpu_pkg::FIELD_W];
        unique case (opc)
          acpu_pkg::OP_HLT: running_next = 1'b0;
          acpu_pkg::OP_ADD: acc_next = acc + ram_rd;
          acpu_pkg::OP_SUB: acc_next = acc - ram_rd;
          acpu_pkg::OP_STO: ram_we = 1'b1;
          acpu_pkg::OP_LD:  acc_next = ram_rd;
          acpu_pkg::OP_B:   counter_next = {1'b0, opd} - 1'b1;
          acpu_pkg::OP_BZ: begin
            if (acc == '0) counter_next = {1'b0, opd} - 1'b1;
          end
          acpu_pkg::OP_LDV: acc_next = DATA_WIDTH'(opd);
          acpu_pkg::OP_INP: acc_next = DATA_WIDTH'(item.input_value);
          acpu_pkg::OP_OUT: begin
            out_reg_next = acc;
            strobe       = 1'b1;
          end
          acpu_pkg::OP_AND: acc_next = acc & ram_rd;
          acpu_pkg::OP_OR:  acc_next = acc | ram_rd;
          acpu_pkg::OP_NOT: acc_next = ~acc;
          default: ;  // spare opcodes do nothing
        endcase
      end
    end
  end

  always_comb begin
    result.executed        = exec;
    result.opcode_done     = opc;
    result.operand_done    = exec ? opd : '0;
    result.acc_value       = acc_next[acpu_pkg::FIELD_W-1:0];
    result.out_strobe      = strobe;
    result.out_value       = out_reg_next[acpu_pkg::FIELD_W-1:0];
    result.program_counter = counter_next;
    result.is_running      = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      out_reg <= '0;
      counter <= acpu_pkg::PC_IDLE;
      running <= 1'b0;
      for (int i = 0; i < acpu_pkg::RAM_WORDS; i++) data_ram[i] <= '0;
    end else if (fire) begin
      acc     <= acc_next;
      out_reg <= out_reg_next;
      counter <= counter_next;
      running <= running_next;
      if (ram_we) data_ram[ram_addr] <= acc;
    end
  end

endmodule

// File: design/four_bit_accumulator_cpu_top.sv
// ----------------------------------------------------------------------------
// four_bit_accumulator_cpu_top
// tiny accumulator cpu: 16-word program in two config registers, at most one
// instruction per tick item
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  -------   ---  ---------------   ----------------------------------------
//  s_*       in   tvalid / tready   tuser: command, tdata: input_value
//  m_*       out  tvalid / tready   tdata: packed result fields (24 bits)
//  cfg_*     in   cfg_we            cfg_index selects program_low / high
//
//  one item per clock sustained while m_tready stays high; each transfer sees
//  the state left by the previous one
//  registered twice: input register, then execute into the result register
//  execute is a single pass over the 16-entry data ram and program fetch
//  rst (synchronous) clears the state, data ram and program registers
//  a stalled m side holds the result; an empty input register still takes
//  one item, then refills only while the result register drains
//
module four_bit_accumulator_cpu_top #(
  parameter int DATA_WIDTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [3:0] input_value, [7:4] zero
  input  logic                              s_tuser,   // [0] command (0 tick, 1 start)
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] executed, [4:1] opcode_done, [8:5] operand_done, [12:9] acc_value,
  // [13] out_strobe, [17:14] out_value, [22:18] program_counter, [23] is_running
  output logic [acpu_pkg::RESULT_W-1:0]     m_tdata,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [acpu_pkg::PROG_REG_W-1:0]   cfg_data
);

  // input register
  logic                 in_valid;
  acpu_pkg::item_t      in_item;
  logic                 fire;

  // execute interface
  logic [acpu_pkg::PROG_AW-1:0] fetch_addr;
  logic [acpu_pkg::WORD_W-1:0]  fetch_word;
  acpu_pkg::result_t            result;

  // execute when an item waits and the result register is free or draining
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command     <= s_tuser;
      in_item.input_value <= s_tdata[acpu_pkg::FIELD_W-1:0];
    end
  end

  acpu_prog u_prog (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fetch_addr (fetch_addr),
    .fetch_word (fetch_word)
  );

  acpu_exec #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (in_item),
    .fetch_word (fetch_word),
    .fetch_addr (fetch_addr),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= result;
    end
  end

endmodule
